// ===== rtl/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types, constants and helpers of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // field widths of the pixel ports
  localparam int unsigned HueW    = 15;
  localparam int unsigned InW     = 8;
  localparam int unsigned OutW    = 8;
  localparam int unsigned FracW   = 12;
  localparam int unsigned SectorW = 3;

  // default level resolution and queue depth
  localparam int unsigned ChannelBitsDef = 8;
  localparam int unsigned FifoDepth      = 2;

  // register stages of one constant divider
  localparam int unsigned DivStages = 2;

  // hue units of one 60 degree sector, and the last legal hue
  localparam int unsigned     SectorUnits = 3840;
  localparam logic [HueW-1:0] HueLast     = 15'd23039;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [InW-1:0]  saturation;
    logic [InW-1:0]  brightness;
  } hsv_pix_t;

  typedef struct packed {
    logic [OutW-1:0] red;
    logic [OutW-1:0] green;
    logic [OutW-1:0] blue;
  } rgb_pix_t;

  // the six hue sectors, named by the colors they span
  typedef enum logic [SectorW-1:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  // hue at the start of a sector
  function automatic logic [HueW-1:0] sector_base(sector_e sec);
    logic [HueW-1:0] base;
    case (sec)
      SEC_RY:  base = '0;
      SEC_YG:  base = HueW'(SectorUnits);
      SEC_GC:  base = HueW'(2 * SectorUnits);
      SEC_CB:  base = HueW'(3 * SectorUnits);
      SEC_BM:  base = HueW'(4 * SectorUnits);
      SEC_MR:  base = HueW'(5 * SectorUnits);
      default: base = '0;
    endcase
    return base;
  endfunction

  // sector of a clamped hue
  function automatic sector_e hue_sector(logic [HueW-1:0] h);
    sector_e sec;
    if (h >= HueW'(5 * SectorUnits)) begin
      sec = SEC_MR;
    end else if (h >= HueW'(4 * SectorUnits)) begin
      sec = SEC_BM;
    end else if (h >= HueW'(3 * SectorUnits)) begin
      sec = SEC_CB;
    end else if (h >= HueW'(2 * SectorUnits)) begin
      sec = SEC_GC;
    end else if (h >= HueW'(SectorUnits)) begin
      sec = SEC_YG;
    end else begin
      sec = SEC_RY;
    end
    return sec;
  endfunction

endpackage

// ===== rtl/hsv2rgb_front.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_front
// Accepts pixels, clamps the hue, splits it into sector and fraction and
// limits saturation and value to full scale. One register stage.
// ----------------------------------------------------------------------------
module hsv2rgb_front import hsv2rgb_pkg::*; #(
  parameter int unsigned ChannelBits = ChannelBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  hsv_pix_t               in_pix_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sector_e                out_sector_o,
  output logic [FracW-1:0]       out_frac_o,
  output logic [ChannelBits-1:0] out_sat_o,
  output logic [ChannelBits-1:0] out_val_o
);

  localparam int unsigned ExtW = ChannelBits + InW;
  localparam logic [ExtW-1:0] ChanMax = ExtW'((1 << ChannelBits) - 1);

  logic                   valid_q;
  logic                   take;
  logic [HueW-1:0]        hue_c;
  logic [HueW-1:0]        hue_off;
  sector_e                sec_d, sec_q;
  logic [FracW-1:0]       frac_d, frac_q;
  logic [ExtW-1:0]        sat_ext, val_ext;
  logic [ChannelBits-1:0] sat_d, sat_q, val_d, val_q;

  // clamp hue and split into sector and fraction
  always_comb begin
    hue_c   = (in_pix_i.hue > HueLast) ? HueLast : in_pix_i.hue;
    sec_d   = hue_sector(hue_c);
    hue_off = hue_c - sector_base(sec_d);
    frac_d  = hue_off[FracW-1:0];
  end

  // limit saturation and value to full scale
  always_comb begin
    sat_ext = ExtW'(in_pix_i.saturation);
    val_ext = ExtW'(in_pix_i.brightness);
    sat_d   = (sat_ext > ChanMax) ? ChanMax[ChannelBits-1:0] : sat_ext[ChannelBits-1:0];
    val_d   = (val_ext > ChanMax) ? ChanMax[ChannelBits-1:0] : val_ext[ChannelBits-1:0];
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      sec_q  <= sec_d;
      frac_q <= frac_d;
      sat_q  <= sat_d;
      val_q  <= val_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_sector_o = sec_q;
  assign out_frac_o   = frac_q;
  assign out_sat_o    = sat_q;
  assign out_val_o    = val_q;

endmodule

// ===== rtl/hsv2rgb_fifo.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_fifo
// Small queue between the front and the back, one beat in and one out
// per cycle; it takes a beat only when not full, gives one when not empty.
// ----------------------------------------------------------------------------
module hsv2rgb_fifo import hsv2rgb_pkg::*; #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  logic [Width-1:0] mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;

  function automatic logic [PtrW-1:0] ptr_next(logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(FifoDepth - 1)) ? '0 : ptr + PtrW'(1);
  endfunction

  assign in_ready_o  = cnt_q != CntW'(FifoDepth);
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

// ===== rtl/hsv2rgb_cdiv.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_cdiv
// Truncating division by a constant through a multiply by its rounded-up
// reciprocal, in two register stages: partial products against the two
// halves of the reciprocal, then their sum. Exact for every dividend of
// NumW bits when the top bit of the divisor is set.
// ----------------------------------------------------------------------------
module hsv2rgb_cdiv #(
  parameter int unsigned          NumW    = 28,
  parameter int unsigned          DivW    = 20,
  parameter logic [DivW-1:0]      Divisor = '1,
  parameter int unsigned          QuotW   = 8
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NumW-1:0]  num_i,
  output logic [QuotW-1:0] quo_o
);

  // scale of 2^(NumW+DivW) keeps the reciprocal error under one step
  localparam int unsigned     ShW     = NumW + DivW;
  localparam int unsigned     PowW    = ShW + 1;
  localparam int unsigned     RecW    = NumW + 2;
  localparam int unsigned     LoW     = RecW / 2;
  localparam int unsigned     HiW     = RecW - LoW;
  localparam int unsigned     LoPW    = NumW + LoW;
  localparam int unsigned     HiPW    = NumW + HiW;
  localparam int unsigned     PrdW    = NumW + RecW;
  localparam logic [ShW:0]    Pow     = PowW'(1) << ShW;
  localparam logic [ShW:0]    DivExt  = PowW'(Divisor);
  localparam logic [ShW:0]    RecFull = (Pow + DivExt - PowW'(1)) / DivExt;
  localparam logic [RecW-1:0] Rec     = RecFull[RecW-1:0];
  localparam logic [LoW-1:0]  RecLo   = Rec[LoW-1:0];
  localparam logic [HiW-1:0]  RecHi   = Rec[RecW-1:LoW];

  logic [LoPW-1:0]  lo_q;
  logic [HiPW-1:0]  hi_q;
  logic [PrdW-1:0]  prod;
  logic [QuotW-1:0] quo_q;

  // partial products against both reciprocal halves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q <= LoPW'(num_i) * LoPW'(RecLo);
      hi_q <= HiPW'(num_i) * HiPW'(RecHi);
    end
  end

  // recombine and keep the integer part
  assign prod = (PrdW'(hi_q) << LoW) + PrdW'(lo_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_q <= prod[ShW +: QuotW];
    end
  end

  assign quo_o = quo_q;

endmodule

// ===== rtl/hsv2rgb_back.sv =====
// ----------------------------------------------------------------------------
// hsv2rgb_back
// Computes the three intermediate levels with exact truncating division,
// maps them to red, green and blue by sector and holds the result.
// ----------------------------------------------------------------------------
module hsv2rgb_back import hsv2rgb_pkg::*; #(
  parameter int unsigned ChannelBits = ChannelBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sector_e                in_sector_i,
  input  logic [FracW-1:0]       in_frac_i,
  input  logic [ChannelBits-1:0] in_sat_i,
  input  logic [ChannelBits-1:0] in_val_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rgb_pix_t               out_pix_o,
  output logic                   busy_o
);

  localparam int unsigned CB    = ChannelBits;
  localparam int unsigned LvlW  = CB + FracW;
  localparam int unsigned NumQW = CB + LvlW;
  localparam int unsigned NumPW = 2 * CB;
  localparam int unsigned ExtW  = CB + OutW;
  localparam int unsigned Depth = DivStages + 2;

  localparam logic [CB-1:0]   ChanMax = '1;
  localparam logic [LvlW-1:0] Den     = LvlW'(SectorUnits) * LvlW'(ChanMax);

  logic             adv;
  logic [Depth-1:0] vld_q;
  logic             out_valid_q;
  rgb_pix_t         out_pix_q;
  rgb_pix_t         pix_d;

  // stage 0: saturation products
  logic [LvlW-1:0] sf, sg;
  sector_e         sec0_q;
  logic [CB-1:0]   v0_q, mp0_q;
  logic [LvlW-1:0] mq0_q, mt0_q;

  // stage 1: value products
  sector_e          sec1_q;
  logic [CB-1:0]    v1_q;
  logic [NumQW-1:0] nq1_q, nt1_q;
  logic [NumPW-1:0] np1_q;

  // sideband along the divider stages
  sector_e       sec_pipe_q [DivStages];
  logic [CB-1:0] v_pipe_q   [DivStages];

  logic [CB-1:0] lvl_p, lvl_q, lvl_t, lvl_v;

  function automatic logic [OutW-1:0] to_out(logic [CB-1:0] x);
    logic [ExtW-1:0] e;
    e = ExtW'(x);
    return e[OutW-1:0];
  endfunction

  // whole pipe moves unless the output beat is held
  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[Depth-2:0], in_valid_i};
      out_valid_q <= vld_q[Depth-1];
    end
  end

  // s*f and s*(1-f) in hue units
  always_comb begin
    sf = LvlW'(in_sat_i) * LvlW'(in_frac_i);
    sg = LvlW'(in_sat_i) * LvlW'(FracW'(SectorUnits) - in_frac_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec0_q <= in_sector_i;
      v0_q   <= in_val_i;
      mp0_q  <= ChanMax - in_sat_i;
      mq0_q  <= Den - sf;
      mt0_q  <= Den - sg;
    end
  end

  // numerators of p, q and t
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec1_q <= sec0_q;
      v1_q   <= v0_q;
      nq1_q  <= NumQW'(v0_q) * NumQW'(mq0_q);
      nt1_q  <= NumQW'(v0_q) * NumQW'(mt0_q);
      np1_q  <= NumPW'(v0_q) * NumPW'(mp0_q);
    end
  end

  // one divider lane per level
  hsv2rgb_cdiv #(
    .NumW    (NumPW),
    .DivW    (CB),
    .Divisor (ChanMax),
    .QuotW   (CB)
  ) u_div_p (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (np1_q),
    .quo_o (lvl_p)
  );

  hsv2rgb_cdiv #(
    .NumW    (NumQW),
    .DivW    (LvlW),
    .Divisor (Den),
    .QuotW   (CB)
  ) u_div_q (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (nq1_q),
    .quo_o (lvl_q)
  );

  hsv2rgb_cdiv #(
    .NumW    (NumQW),
    .DivW    (LvlW),
    .Divisor (Den),
    .QuotW   (CB)
  ) u_div_t (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (nt1_q),
    .quo_o (lvl_t)
  );

  // sector and value follow the dividers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sec_pipe_q[0] <= sec1_q;
      v_pipe_q[0]   <= v1_q;
      for (int k = 1; k < DivStages; k++) begin
        sec_pipe_q[k] <= sec_pipe_q[k-1];
        v_pipe_q[k]   <= v_pipe_q[k-1];
      end
    end
  end

  assign lvl_v = v_pipe_q[DivStages-1];

  // six-way channel assignment
  always_comb begin
    case (sec_pipe_q[DivStages-1])
      SEC_RY: pix_d = '{red: to_out(lvl_v), green: to_out(lvl_t), blue: to_out(lvl_p)};
      SEC_YG: pix_d = '{red: to_out(lvl_q), green: to_out(lvl_v), blue: to_out(lvl_p)};
      SEC_GC: pix_d = '{red: to_out(lvl_p), green: to_out(lvl_v), blue: to_out(lvl_t)};
      SEC_CB: pix_d = '{red: to_out(lvl_p), green: to_out(lvl_q), blue: to_out(lvl_v)};
      SEC_BM: pix_d = '{red: to_out(lvl_t), green: to_out(lvl_p), blue: to_out(lvl_v)};
      default: pix_d = '{red: to_out(lvl_v), green: to_out(lvl_p), blue: to_out(lvl_q)};
    endcase
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pix_q <= pix_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;
  assign busy_o      = (|vld_q) || out_valid_q;

endmodule

// ===== rtl/hsv_to_rgb_converter_core.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// HSV to RGB pixel converter with valid/ready streams on both sides.
// ----------------------------------------------------------------------------
// Takes one HSV pixel per clock while not stalled and returns one RGB
// pixel per pixel, in order. Hue is degrees times 64 (values at or above
// 360 degrees clamp to just below it); saturation and brightness are
// fractions of full scale 2^ChannelBits-1. Channels are exact truncated
// levels. The path from input beat to output beat runs through one front
// stage, the queue, two product stages, two stages in the reciprocal
// dividers and the output register. Throughput is one beat per clock
// while the output side takes beats; the queue lets the input side keep
// going while an output beat waits.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_core import hsv2rgb_pkg::*; #(
  parameter int unsigned ChannelBits = ChannelBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  hsv_pix_t in_pix_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rgb_pix_t out_pix_o
);

  localparam int unsigned QWidth    = SectorW + FracW + 2 * ChannelBits;
  localparam int unsigned Capacity  = 1 + FifoDepth + DivStages + 3;
  localparam int unsigned InflightW = $clog2(Capacity + 1);

  logic                   fr_valid, fr_ready;
  sector_e                fr_sector;
  logic [FracW-1:0]       fr_frac;
  logic [ChannelBits-1:0] fr_sat, fr_val;
  logic                   bk_valid, bk_ready;
  logic [QWidth-1:0]      bk_data;
  logic                   back_busy;

  // front: clamp and classify
  hsv2rgb_front #(
    .ChannelBits (ChannelBits)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_pix_i     (in_pix_i),
    .out_valid_o  (fr_valid),
    .out_ready_i  (fr_ready),
    .out_sector_o (fr_sector),
    .out_frac_o   (fr_frac),
    .out_sat_o    (fr_sat),
    .out_val_o    (fr_val)
  );

  // queue between front and back
  hsv2rgb_fifo #(
    .Width (QWidth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_data_i   ({fr_sector, fr_frac, fr_sat, fr_val}),
    .out_valid_o (bk_valid),
    .out_ready_i (bk_ready),
    .out_data_o  (bk_data)
  );

  // back: levels, division and channel mapping
  hsv2rgb_back #(
    .ChannelBits (ChannelBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_ready_o  (bk_ready),
    .in_sector_i (sector_e'(bk_data[QWidth-1 -: SectorW])),
    .in_frac_i   (bk_data[2*ChannelBits +: FracW]),
    .in_sat_i    (bk_data[ChannelBits +: ChannelBits]),
    .in_val_i    (bk_data[ChannelBits-1:0]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_pix_o   (out_pix_o),
    .busy_o      (back_busy)
  );

  // pixels in flight, for the checks below
  logic                 in_beat, out_beat;
  logic [InflightW-1:0] inflight_d, inflight_q;

  assign in_beat  = in_valid_i && in_ready_o;
  assign out_beat = out_valid_o && out_ready_i;

  always_comb begin
    case ({in_beat, out_beat})
      2'b10:   inflight_d = inflight_q + InflightW'(1);
      2'b01:   inflight_d = inflight_q - InflightW'(1);
      default: inflight_d = inflight_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // no output beat without a pixel inside
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != '0)
    else $error("output beat with no pixel in flight");

  // storage never holds more than its stages
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= InflightW'(Capacity))
    else $error("more pixels in flight than storage");

  // an output beat comes out of the back pipe
  a_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(back_busy))
    else $error("output beat appeared from an empty pipe");

  // empty block means an idle back pipe
  a_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q == '0) |-> !back_busy)
    else $error("back pipe busy with nothing in flight");

endmodule
